@@ hw/rtl/tcc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types, codes and reset values of the text console cursor block.
// ----------------------------------------------------------------------------
package tcc_pkg;

  // Field widths.
  localparam int unsigned CharW = 8;
  localparam int unsigned PosW  = 11;
  localparam int unsigned CurW  = 12;
  localparam int unsigned DataW = 32;
  localparam int unsigned AddrW = 4;

  // Depth of the result queue; a power of two, at least 2.
  localparam int unsigned QueueDepthDef = 4;

  // Register reset values.
  localparam logic [PosW-1:0] WidthRst  = 11'd480;
  localparam logic [PosW-1:0] HeightRst = 11'd854;

  // Character codes with a meaning of their own.
  localparam logic [CharW-1:0] CharNul   = 8'h00;
  localparam logic [CharW-1:0] CharBs    = 8'h08;
  localparam logic [CharW-1:0] CharLf    = 8'h0A;
  localparam logic [CharW-1:0] CharSpace = 8'h20;

  typedef enum logic [1:0] {
    REG_WIDTH    = 2'd0,
    REG_HEIGHT   = 2'd1,
    REG_BIG_FONT = 2'd2,
    REG_DOUBLE   = 2'd3
  } reg_idx_e;

  typedef enum logic [0:0] {
    CMD_DRAW   = 1'b0,
    CMD_SCROLL = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [PosW-1:0] screen_width;
    logic [PosW-1:0] screen_height;
    logic            big_font;
    logic            double_scale;
  } cfg_t;

  typedef struct packed {
    cmd_e             command;
    logic [PosW-1:0]  pos_x;
    logic [PosW-1:0]  pos_y;
    logic [CharW-1:0] glyph;
    logic             last;
  } result_t;

  // Up to two results produced by one request, in order.
  typedef struct packed {
    logic [1:0]       num;
    result_t [1:0]    res;
  } push_t;

endpackage
`default_nettype wire

@@ hw/rtl/tcc_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_cfg
// APB register file holding screen size and font settings.
// ----------------------------------------------------------------------------
module tcc_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [tcc_pkg::AddrW-1:0]    paddr,
  input  wire logic [tcc_pkg::DataW-1:0]    pwdata,
  output logic      [tcc_pkg::DataW-1:0]    prdata,
  output logic                              pready,
  output tcc_pkg::cfg_t                     cfg_o
);

  tcc_pkg::cfg_t      cfg_q, cfg_d;
  tcc_pkg::reg_idx_e  idx;
  logic               wr_en;

  assign idx    = tcc_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        tcc_pkg::REG_WIDTH:    cfg_d.screen_width  = pwdata[tcc_pkg::PosW-1:0];
        tcc_pkg::REG_HEIGHT:   cfg_d.screen_height = pwdata[tcc_pkg::PosW-1:0];
        tcc_pkg::REG_BIG_FONT: cfg_d.big_font      = pwdata[0];
        tcc_pkg::REG_DOUBLE:   cfg_d.double_scale  = pwdata[0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      tcc_pkg::REG_WIDTH:
        prdata = {{(tcc_pkg::DataW-tcc_pkg::PosW){1'b0}}, cfg_q.screen_width};
      tcc_pkg::REG_HEIGHT:
        prdata = {{(tcc_pkg::DataW-tcc_pkg::PosW){1'b0}}, cfg_q.screen_height};
      tcc_pkg::REG_BIG_FONT:
        prdata = {{(tcc_pkg::DataW-1){1'b0}}, cfg_q.big_font};
      tcc_pkg::REG_DOUBLE:
        prdata = {{(tcc_pkg::DataW-1){1'b0}}, cfg_q.double_scale};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width  <= tcc_pkg::WidthRst;
      cfg_q.screen_height <= tcc_pkg::HeightRst;
      cfg_q.big_font      <= 1'b0;
      cfg_q.double_scale  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/tcc_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_step
// Input register, cursor registers and the per-character cursor update.
// ----------------------------------------------------------------------------
module tcc_step (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [tcc_pkg::CharW-1:0]    char_code_i,
  input  wire tcc_pkg::cfg_t                cfg_i,
  input  wire logic                         room_i,
  output tcc_pkg::push_t                    push_o
);

  localparam int unsigned CurW    = tcc_pkg::CurW;
  localparam int unsigned PosW    = tcc_pkg::PosW;
  localparam int unsigned CharW_L = tcc_pkg::CharW;

  logic                       vld_q;
  logic [tcc_pkg::CharW-1:0]  char_q;
  logic [CurW-1:0]            cx_q, cx_d, cy_q, cy_d;
  logic                       fire, take;

  logic [4:0]                 cw;
  logic [5:0]                 ch;
  logic [PosW-1:0]            row_top, col_end;
  logic signed [CurW:0]       lim;
  logic                       scroll, wrap, has_draw;
  logic [CurW-1:0]            cx_s, cy_s, dx, dy, cx_adv;
  logic [CharW_L-1:0]         glyph;
  tcc_pkg::result_t           scr_res, drw_res;

  // The held character is processed once the queue can take two results.
  assign fire       = vld_q && room_i;
  assign in_stall_o = vld_q && !room_i;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    cw = cfg_i.big_font ? 5'd8 : 5'd6;
    ch = cfg_i.big_font ? 6'd16 : 6'd8;
    if (cfg_i.double_scale) begin
      cw = {cw[3:0], 1'b0};
      ch = {ch[4:0], 1'b0};
    end
    row_top = (cfg_i.screen_height >= PosW'(ch)) ? cfg_i.screen_height - PosW'(ch) : '0;
    col_end = (cfg_i.screen_width >= PosW'(cw)) ? cfg_i.screen_width - PosW'(cw) : '0;
    lim     = $signed({2'b00, cfg_i.screen_width}) - $signed({8'd0, cw});

    // A cursor below the last full row is pulled back and a scroll goes out, except on a NUL.
    scroll = cy_q > {1'b0, row_top};
    cx_s   = scroll ? '0 : cx_q;
    cy_s   = scroll ? {1'b0, row_top} : cy_q;

    cx_d     = cx_s;
    cy_d     = cy_s;
    dx       = cx_s;
    dy       = cy_s;
    glyph    = char_q;
    has_draw = 1'b0;
    cx_adv   = cx_s + CurW'(cw);
    wrap     = 1'b0;

    case (char_q)
      tcc_pkg::CharNul: begin
        scroll = 1'b0;
        cx_d   = cx_q;
        cy_d   = cy_q;
      end
      tcc_pkg::CharLf: begin
        cx_d = '0;
        cy_d = cy_s + CurW'(ch);
      end
      tcc_pkg::CharBs: begin
        has_draw = 1'b1;
        glyph    = tcc_pkg::CharSpace;
        if (cx_s >= CurW'(cw)) begin
          cx_d = cx_s - CurW'(cw);
        end else begin
          cx_d = {1'b0, col_end};
          cy_d = (cy_s >= CurW'(ch)) ? cy_s - CurW'(ch) : '0;
        end
        // The erase goes to the cell the cursor has just stepped back to.
        dx = cx_d;
        dy = cy_d;
      end
      default: begin
        has_draw = 1'b1;
        // Big font wraps past the last cell start, small font already on it.
        if (cfg_i.big_font) begin
          wrap = $signed({1'b0, cx_adv}) > lim;
        end else begin
          wrap = $signed({1'b0, cx_adv}) >= lim;
        end
        cx_d = wrap ? '0 : cx_adv;
        cy_d = wrap ? cy_s + CurW'(ch) : cy_s;
      end
    endcase

    scr_res.command = tcc_pkg::CMD_SCROLL;
    scr_res.pos_x   = '0;
    scr_res.pos_y   = '0;
    scr_res.glyph   = '0;
    scr_res.last    = !has_draw;

    // A draw starting at or beyond the right edge lands at the start of the next row.
    drw_res.command = tcc_pkg::CMD_DRAW;
    if (dx >= {1'b0, cfg_i.screen_width}) begin
      drw_res.pos_x = '0;
      drw_res.pos_y = PosW'(dy + CurW'(ch));
    end else begin
      drw_res.pos_x = dx[PosW-1:0];
      drw_res.pos_y = dy[PosW-1:0];
    end
    drw_res.glyph = glyph;
    drw_res.last  = 1'b1;

    push_o.res[0] = scroll ? scr_res : drw_res;
    push_o.res[1] = drw_res;
    push_o.num    = fire ? (2'({1'b0, scroll}) + 2'({1'b0, has_draw})) : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      cx_q  <= '0;
      cy_q  <= '0;
    end else begin
      if (take) begin
        vld_q <= 1'b1;
      end else if (fire) begin
        vld_q <= 1'b0;
      end
      if (fire) begin
        cx_q <= cx_d;
        cy_q <= cy_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      char_q <= char_code_i;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/tcc_resq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_resq
// Result queue: takes up to two results per cycle, hands out one per cycle unless stalled.
// ----------------------------------------------------------------------------
module tcc_resq #(
  parameter int unsigned Depth = tcc_pkg::QueueDepthDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire tcc_pkg::push_t push_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output tcc_pkg::result_t   head_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  tcc_pkg::result_t   mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               pop;

  assign out_valid_o = cnt_q != '0;
  assign pop         = out_valid_o && !out_stall_i;
  assign room_o      = cnt_q <= CntW'(Depth - 2);
  assign head_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_i.num);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    cnt_d    = cnt_q + CntW'(push_i.num) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res[0];
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_ptr_q + PtrW'(1)] <= push_i.res[1];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/text_console_cursor.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_cursor
// Turns a character stream into glyph draw and scroll requests.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake                 Payload
//   input     in         in_valid_i / in_stall_o   char_code_i
//   output    out        out_valid_o / out_stall_i command, pos_x, pos_y, glyph, last
//   config    in         APB psel/penable/pwrite   paddr, pwdata, prdata
//
// One character per cycle while the input is not stalled: a request enters the
// input register, and the cursor update then pushes its zero to two results
// into the queue once two entries are free. The output port drains one result
// per cycle while not stalled, so characters that both scroll and draw outpace it.
// Reset clears the cursor to the top-left cell and loads the default screen.
// An output stall fills the queue, and input stalls once fewer than two
// entries are free.
// ----------------------------------------------------------------------------
module text_console_cursor #(
  parameter int unsigned QueueDepth = tcc_pkg::QueueDepthDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [tcc_pkg::CharW-1:0]    char_code_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              command_o,
  output logic      [tcc_pkg::PosW-1:0]     pos_x_o,
  output logic      [tcc_pkg::PosW-1:0]     pos_y_o,
  output logic      [tcc_pkg::CharW-1:0]    glyph_o,
  output logic                              last_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [tcc_pkg::AddrW-1:0]    paddr,
  input  wire logic [tcc_pkg::DataW-1:0]    pwdata,
  output logic      [tcc_pkg::DataW-1:0]    prdata,
  output logic                              pready
);

  tcc_pkg::cfg_t     cfg;
  tcc_pkg::push_t    push;
  tcc_pkg::result_t  head;
  logic              room;

  tcc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tcc_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .cfg_i       (cfg),
    .room_i      (room),
    .push_o      (push)
  );

  tcc_resq #(
    .Depth (QueueDepth)
  ) u_resq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign command_o = head.command;
  assign pos_x_o   = head.pos_x;
  assign pos_y_o   = head.pos_y;
  assign glyph_o   = head.glyph;
  assign last_o    = head.last;

endmodule
`default_nettype wire

@@ hw/rtl/tcc_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_chk
// Port-level checks of the text console cursor, bound to the top level.
// ----------------------------------------------------------------------------
module tcc_chk (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire logic                         command_o,
  input wire logic [tcc_pkg::PosW-1:0]     pos_x_o,
  input wire logic [tcc_pkg::PosW-1:0]     pos_y_o,
  input wire logic [tcc_pkg::CharW-1:0]    glyph_o,
  input wire logic                         last_o
);

  // No result is offered while reset is held.
  a_quiet_in_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result offered during reset");

  // A scroll request carries no position and no glyph.
  a_scroll_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && command_o == tcc_pkg::CMD_SCROLL) |->
      (pos_x_o == '0 && pos_y_o == '0 && glyph_o == '0))
    else $error("scroll request with nonzero payload");

  // A draw is always the final result of its character.
  a_draw_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && command_o == tcc_pkg::CMD_DRAW) |-> last_o)
    else $error("draw request not marked last");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result withdrawn while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      ($stable(command_o) && $stable(pos_x_o) && $stable(pos_y_o) &&
       $stable(glyph_o) && $stable(last_o)))
    else $error("stalled result changed");

endmodule

bind text_console_cursor tcc_chk u_chk (.*);
`default_nettype wire
